### hw/rtl/tpsc_pkg.sv
// Shared constants for the two-port stability circle block.
package tpsc_pkg;

    localparam int SPARAM_WIDTH_DEF = 18;
    localparam int RESULT_WIDTH_DEF = 32;

    // Fraction bits of the S-parameters and of the results
    localparam int IN_FRAC  = 12;
    localparam int OUT_FRAC = 16;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd2;

endpackage

### hw/rtl/tpsc_if.sv
// Valid/ready channel interfaces for S-parameter sets and circle results.
interface tpsc_in_if #(
    parameter int W = tpsc_pkg::SPARAM_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic                side;
    logic signed [W-1:0] s11_re;
    logic signed [W-1:0] s11_im;
    logic signed [W-1:0] s12_re;
    logic signed [W-1:0] s12_im;
    logic signed [W-1:0] s21_re;
    logic signed [W-1:0] s21_im;
    logic signed [W-1:0] s22_re;
    logic signed [W-1:0] s22_im;

    modport source (
        output valid, side, s11_re, s11_im, s12_re, s12_im,
               s21_re, s21_im, s22_re, s22_im,
        input  ready
    );
    modport sink (
        input  valid, side, s11_re, s11_im, s12_re, s12_im,
               s21_re, s21_im, s22_re, s22_im,
        output ready
    );
endinterface

interface tpsc_out_if #(
    parameter int RW = tpsc_pkg::RESULT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [RW-1:0]          center_re;
    logic signed [RW-1:0]          center_im;
    logic [RW-1:0]                 radius;
    logic [tpsc_pkg::STATUS_W-1:0] status;

    modport source (
        output valid, center_re, center_im, radius, status,
        input  ready
    );
    modport sink (
        input  valid, center_re, center_im, radius, status,
        output ready
    );
endinterface

### hw/rtl/tpsc_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flag.
module tpsc_div #(
    parameter int NUMW = 64,
    parameter int DENW = 32,
    parameter int QW   = 32
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic [QW-1:0]   q,
    output logic            big
);

    localparam int CW = (NUMW > DENW + QW) ? NUMW : DENW + QW;

    logic [CW-1:0]   rem_reg [0:QW-1];
    logic [DENW-1:0] den_reg [0:QW-1];
    logic [QW-1:0]   q_reg   [0:QW];
    logic            big_reg [0:QW];

    // Flag quotients that do not fit in QW bits up front
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            big_reg[0] <= CW'(num) >= (CW'(den) << QW);
        end
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        localparam int SH = QW - j;
        logic [CW-1:0] trial;
        logic          ge;

        assign trial = CW'(den_reg[j-1]) << SH;
        assign ge    = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j]   <= {q_reg[j-1][QW-2:0], ge};
                big_reg[j] <= big_reg[j-1];
            end
        end

        if (j < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? rem_reg[j-1] - trial : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end
    end

    assign q   = q_reg[QW];
    assign big = big_reg[QW];

endmodule

### hw/rtl/two_port_stability_circle_top.sv
// Two-port stability circle: center and radius of the input or output circle.
//
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+-------------------
//  sparam   | in  | side, s11..s22 re/im (signed Q.12)        | valid && ready
//  circle   | out | center_re/im (Q.16), radius (Q.16), status | valid && ready
//
// One parameter set enters per cycle while ready is high. The square-root stages
// and the quotient-bit stages of the dividers make up most of the pipeline to the
// output buffer.
// Reset clears the valid bits and the two-entry output buffer; no memory to clear.
// When both output buffer entries are full, ready drops and the whole pipeline holds.
module two_port_stability_circle_top #(
    parameter int SPARAM_WIDTH = tpsc_pkg::SPARAM_WIDTH_DEF,
    parameter int RESULT_WIDTH = tpsc_pkg::RESULT_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tpsc_in_if.sink    sparam,
    tpsc_out_if.source circle
);

    localparam int W    = SPARAM_WIDTH;
    localparam int RW   = RESULT_WIDTH;
    localparam int SH2  = 2 * tpsc_pkg::IN_FRAC;
    localparam int SHC  = tpsc_pkg::OUT_FRAC + tpsc_pkg::IN_FRAC;
    localparam int PW   = 2 * W;
    localparam int SW   = 2 * W + 1;
    localparam int DW   = 2 * W + 2;
    localparam int HD   = W + 1;
    localparam int HS   = W + 1;
    localparam int PRW  = 2 * W + 4;
    localparam int PPW  = PW + 1;
    localparam int D2SQ = 2 * DW;
    localparam int D2W  = D2SQ + 1;
    localparam int DENW = ((PPW + SH2 > D2W) ? PPW + SH2 : D2W) + 1;
    localparam int DQW  = DW + W;
    localparam int NRW  = ((DQW + 1 > W + SH2) ? DQW + 1 : W + SH2) + 1;
    localparam int S2W  = 2 * SW;
    localparam int SQW  = 4 * W;
    localparam int VW   = SQW + 2 * tpsc_pkg::OUT_FRAC;
    localparam int RTW  = VW / 2;
    localparam int REMW = RTW + 2;
    localparam int SBN  = RTW + RW + 1;
    localparam int L    = RTW + RW + 7;

    localparam logic [RW-1:0] HALF = {1'b1, {(RW-1){1'b0}}};

    typedef struct packed {
        logic zero;
        logic neg_re;
        logic neg_im;
    } side_t;

    typedef struct packed {
        logic [RW-1:0]                 center_re;
        logic [RW-1:0]                 center_im;
        logic [RW-1:0]                 radius;
        logic [tpsc_pkg::STATUS_W-1:0] status;
    } result_t;

    function automatic logic [RW:0] fmt_center(input logic [RW-1:0] q, input logic big,
                                               input logic neg);
        logic          sat;
        logic [RW-1:0] val;
        if (neg)
        begin
            sat = big || (q > HALF);
            val = sat ? HALF : (~q + 1'b1);
        end
        else
        begin
            sat = big || q[RW-1];
            val = sat ? ~HALF : q;
        end
        return {sat, val};
    endfunction

    logic en;
    logic vld_reg [1:L];
    logic [1:0] out_cnt_reg;

    assign en = (out_cnt_reg != 2'd2);
    assign sparam.ready = en;

    // Stage 1: all W x W products
    logic signed [W-1:0] p_re, p_im, q_re, q_im;
    assign p_re = sparam.side ? sparam.s22_re : sparam.s11_re;
    assign p_im = sparam.side ? sparam.s22_im : sparam.s11_im;
    assign q_re = sparam.side ? sparam.s11_re : sparam.s22_re;
    assign q_im = sparam.side ? sparam.s11_im : sparam.s22_im;

    logic signed [PW-1:0] x_rr_reg, x_ii_reg, x_ri_reg, x_ir_reg;
    logic signed [PW-1:0] pq_rr_reg, pq_ii_reg, pq_ri_reg, pq_ir_reg;
    logic signed [PW-1:0] pp_r_reg, pp_i_reg;
    logic signed [W-1:0]  p1_re_reg, p1_im_reg, q1_re_reg, q1_im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_rr_reg  <= PW'(sparam.s12_re) * PW'(sparam.s21_re);
            x_ii_reg  <= PW'(sparam.s12_im) * PW'(sparam.s21_im);
            x_ri_reg  <= PW'(sparam.s12_re) * PW'(sparam.s21_im);
            x_ir_reg  <= PW'(sparam.s12_im) * PW'(sparam.s21_re);
            pq_rr_reg <= PW'(p_re) * PW'(q_re);
            pq_ii_reg <= PW'(p_im) * PW'(q_im);
            pq_ri_reg <= PW'(p_re) * PW'(q_im);
            pq_ir_reg <= PW'(p_im) * PW'(q_re);
            pp_r_reg  <= PW'(p_re) * PW'(p_re);
            pp_i_reg  <= PW'(p_im) * PW'(p_im);
            p1_re_reg <= p_re;
            p1_im_reg <= p_im;
            q1_re_reg <= q_re;
            q1_im_reg <= q_im;
        end
    end

    // Stage 2: s12*s21, delta, |p|^2
    logic signed [SW-1:0]  s_re_reg, s_im_reg;
    logic signed [DW-1:0]  d_re_reg, d_im_reg;
    logic signed [PPW-1:0] pmag_reg;
    logic signed [W-1:0]   p2_re_reg, p2_im_reg, q2_re_reg, q2_im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_re_reg  <= SW'(x_rr_reg) - SW'(x_ii_reg);
            s_im_reg  <= SW'(x_ri_reg) + SW'(x_ir_reg);
            d_re_reg  <= DW'(pq_rr_reg) - DW'(pq_ii_reg) - DW'(x_rr_reg) + DW'(x_ii_reg);
            d_im_reg  <= DW'(pq_ri_reg) + DW'(pq_ir_reg) - DW'(x_ri_reg) - DW'(x_ir_reg);
            pmag_reg  <= PPW'(pp_r_reg) + PPW'(pp_i_reg);
            p2_re_reg <= p1_re_reg;
            p2_im_reg <= p1_im_reg;
            q2_re_reg <= q1_re_reg;
            q2_im_reg <= q1_im_reg;
        end
    end

    // Stage 3: split the wide operands into high and low halves and form the partial products
    logic signed [W:0]    drh, dih;
    logic signed [HD:0]   drl, dil;
    logic signed [W-1:0]  srh, sih;
    logic signed [HS:0]   srl, sil;

    assign drh = $signed(d_re_reg[DW-1:HD]);
    assign dih = $signed(d_im_reg[DW-1:HD]);
    assign drl = $signed({1'b0, d_re_reg[HD-1:0]});
    assign dil = $signed({1'b0, d_im_reg[HD-1:0]});
    assign srh = $signed(s_re_reg[SW-1:HS]);
    assign sih = $signed(s_im_reg[SW-1:HS]);
    assign srl = $signed({1'b0, s_re_reg[HS-1:0]});
    assign sil = $signed({1'b0, s_im_reg[HS-1:0]});

    logic signed [PRW-1:0] drr_hh_reg, drr_hl_reg, drr_ll_reg;
    logic signed [PRW-1:0] dii_hh_reg, dii_hl_reg, dii_ll_reg;
    logic signed [PRW-1:0] srr_hh_reg, srr_hl_reg, srr_ll_reg;
    logic signed [PRW-1:0] sii_hh_reg, sii_hl_reg, sii_ll_reg;
    logic signed [PRW-1:0] drqr_h_reg, drqr_l_reg, drqi_h_reg, drqi_l_reg;
    logic signed [PRW-1:0] diqr_h_reg, diqr_l_reg, diqi_h_reg, diqi_l_reg;
    logic signed [PPW-1:0] pmag3_reg;
    logic signed [W-1:0]   p3_re_reg, p3_im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drr_hh_reg <= PRW'(drh) * PRW'(drh);
            drr_hl_reg <= PRW'(drh) * PRW'(drl);
            drr_ll_reg <= PRW'(drl) * PRW'(drl);
            dii_hh_reg <= PRW'(dih) * PRW'(dih);
            dii_hl_reg <= PRW'(dih) * PRW'(dil);
            dii_ll_reg <= PRW'(dil) * PRW'(dil);
            srr_hh_reg <= PRW'(srh) * PRW'(srh);
            srr_hl_reg <= PRW'(srh) * PRW'(srl);
            srr_ll_reg <= PRW'(srl) * PRW'(srl);
            sii_hh_reg <= PRW'(sih) * PRW'(sih);
            sii_hl_reg <= PRW'(sih) * PRW'(sil);
            sii_ll_reg <= PRW'(sil) * PRW'(sil);
            drqr_h_reg <= PRW'(drh) * PRW'(q2_re_reg);
            drqr_l_reg <= PRW'(drl) * PRW'(q2_re_reg);
            drqi_h_reg <= PRW'(drh) * PRW'(q2_im_reg);
            drqi_l_reg <= PRW'(drl) * PRW'(q2_im_reg);
            diqr_h_reg <= PRW'(dih) * PRW'(q2_re_reg);
            diqr_l_reg <= PRW'(dil) * PRW'(q2_re_reg);
            diqi_h_reg <= PRW'(dih) * PRW'(q2_im_reg);
            diqi_l_reg <= PRW'(dil) * PRW'(q2_im_reg);
            pmag3_reg  <= pmag_reg;
            p3_re_reg  <= p2_re_reg;
            p3_im_reg  <= p2_im_reg;
        end
    end

    // Stage 4: recombine the partial products
    logic signed [D2SQ-1:0] dsq_re_reg, dsq_im_reg;
    logic signed [S2W-1:0]  ssq_re_reg, ssq_im_reg;
    logic signed [DQW-1:0]  dq_rr_reg, dq_ri_reg, dq_ir_reg, dq_ii_reg;
    logic signed [PPW-1:0]  pmag4_reg;
    logic signed [W-1:0]    p4_re_reg, p4_im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_re_reg <= (D2SQ'(drr_hh_reg) <<< (2 * HD)) + (D2SQ'(drr_hl_reg) <<< (HD + 1))
                          + D2SQ'(drr_ll_reg);
            dsq_im_reg <= (D2SQ'(dii_hh_reg) <<< (2 * HD)) + (D2SQ'(dii_hl_reg) <<< (HD + 1))
                          + D2SQ'(dii_ll_reg);
            ssq_re_reg <= (S2W'(srr_hh_reg) <<< (2 * HS)) + (S2W'(srr_hl_reg) <<< (HS + 1))
                          + S2W'(srr_ll_reg);
            ssq_im_reg <= (S2W'(sii_hh_reg) <<< (2 * HS)) + (S2W'(sii_hl_reg) <<< (HS + 1))
                          + S2W'(sii_ll_reg);
            dq_rr_reg  <= (DQW'(drqr_h_reg) <<< HD) + DQW'(drqr_l_reg);
            dq_ri_reg  <= (DQW'(drqi_h_reg) <<< HD) + DQW'(drqi_l_reg);
            dq_ir_reg  <= (DQW'(diqr_h_reg) <<< HD) + DQW'(diqr_l_reg);
            dq_ii_reg  <= (DQW'(diqi_h_reg) <<< HD) + DQW'(diqi_l_reg);
            pmag4_reg  <= pmag3_reg;
            p4_re_reg  <= p3_re_reg;
            p4_im_reg  <= p3_im_reg;
        end
    end

    // Stage 5: denominator, center numerators, |s12*s21|^2
    logic signed [DENW-1:0] den5_reg;
    logic signed [NRW-1:0]  nr5_reg, ni5_reg;
    logic [SQW-1:0]         smag5_reg;
    logic signed [S2W:0]    ssum;

    assign ssum = (S2W+1)'(ssq_re_reg) + (S2W+1)'(ssq_im_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den5_reg  <= (DENW'(pmag4_reg) <<< SH2) - DENW'(dsq_re_reg) - DENW'(dsq_im_reg);
            nr5_reg   <= (NRW'(p4_re_reg) <<< SH2) - NRW'(dq_rr_reg) - NRW'(dq_ii_reg);
            ni5_reg   <= (NRW'(p4_im_reg) <<< SH2) - NRW'(dq_ir_reg) + NRW'(dq_ri_reg);
            smag5_reg <= ssum[SQW-1:0];
        end
    end

    // Stage 6: signs and magnitudes; then the square root, operands delayed alongside
    side_t sb_next;
    logic  ni_pos;

    assign ni_pos         = !ni5_reg[NRW-1] && (ni5_reg != '0);
    assign sb_next.zero   = (den5_reg == '0);
    assign sb_next.neg_re = nr5_reg[NRW-1] ^ den5_reg[DENW-1];
    assign sb_next.neg_im = ni_pos ^ den5_reg[DENW-1];

    side_t           sb_reg      [0:SBN];
    logic [NRW-1:0]  nre_dly_reg [0:RTW];
    logic [NRW-1:0]  nim_dly_reg [0:RTW];
    logic [DENW-1:0] den_dly_reg [0:RTW];
    logic [VW-1:0]   sq_v_reg    [0:RTW];
    logic [REMW-1:0] rem_reg     [0:RTW];
    logic [RTW-1:0]  root_reg    [0:RTW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0]      <= sb_next;
            nre_dly_reg[0] <= nr5_reg[NRW-1] ? NRW'(-nr5_reg) : NRW'(nr5_reg);
            nim_dly_reg[0] <= ni5_reg[NRW-1] ? NRW'(-ni5_reg) : NRW'(ni5_reg);
            den_dly_reg[0] <= den5_reg[DENW-1] ? DENW'(-den5_reg) : DENW'(den5_reg);
            sq_v_reg[0]    <= {smag5_reg, {(2 * tpsc_pkg::OUT_FRAC){1'b0}}};
            rem_reg[0]     <= '0;
            root_reg[0]    <= '0;
        end
    end

    // One root bit per stage: bring down two radicand bits, try (root << 2) | 1
    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        assign rem_sh = {rem_reg[k][REMW-3:0], sq_v_reg[k][VW-1:VW-2]};
        assign trial  = {root_reg[k], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]     <= ge ? rem_sh - trial : rem_sh;
                root_reg[k+1]    <= {root_reg[k][RTW-2:0], ge};
                sq_v_reg[k+1]    <= {sq_v_reg[k][VW-3:0], 2'b00};
                nre_dly_reg[k+1] <= nre_dly_reg[k];
                nim_dly_reg[k+1] <= nim_dly_reg[k];
                den_dly_reg[k+1] <= den_dly_reg[k];
            end
        end
    end

    for (genvar k = 1; k <= SBN; k++)
    begin : g_sb
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // Dividers: two center parts and the radius share the denominator magnitude
    logic [RW-1:0] qd_re, qd_im, qd_rad;
    logic          big_re, big_im, big_rad;

    tpsc_div #(.NUMW(NRW + SHC), .DENW(DENW), .QW(RW)) u_div_re (
        .clk (clk),
        .en  (en),
        .num ({nre_dly_reg[RTW], {SHC{1'b0}}}),
        .den (den_dly_reg[RTW]),
        .q   (qd_re),
        .big (big_re)
    );

    tpsc_div #(.NUMW(NRW + SHC), .DENW(DENW), .QW(RW)) u_div_im (
        .clk (clk),
        .en  (en),
        .num ({nim_dly_reg[RTW], {SHC{1'b0}}}),
        .den (den_dly_reg[RTW]),
        .q   (qd_im),
        .big (big_im)
    );

    tpsc_div #(.NUMW(RTW + SH2), .DENW(DENW), .QW(RW)) u_div_rad (
        .clk (clk),
        .en  (en),
        .num ({root_reg[RTW], {SH2{1'b0}}}),
        .den (den_dly_reg[RTW]),
        .q   (qd_rad),
        .big (big_rad)
    );

    // Saturate and pack the finished result
    logic [RW:0] fre, fim;
    result_t     res;

    assign fre = fmt_center(qd_re, big_re, sb_reg[SBN].neg_re);
    assign fim = fmt_center(qd_im, big_im, sb_reg[SBN].neg_im);

    always_comb
    begin
        if (sb_reg[SBN].zero)
        begin
            res.center_re = '0;
            res.center_im = '0;
            res.radius    = '0;
            res.status    = tpsc_pkg::STATUS_ZERO_DEN;
        end
        else
        begin
            res.center_re = fre[RW-1:0];
            res.center_im = fim[RW-1:0];
            res.radius    = big_rad ? '1 : qd_rad;
            res.status    = (fre[RW] || fim[RW] || big_rad) ? tpsc_pkg::STATUS_SAT
                                                            : tpsc_pkg::STATUS_OK;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= L; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= sparam.valid;
            for (int i = 2; i <= L; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Two-entry output buffer: head drives the port, skid catches the overflow
    logic       push, pop;
    logic [1:0] out_cnt_next;
    result_t    out_head_reg, out_skid_reg;

    assign push = en && vld_reg[L];
    assign pop  = circle.valid && circle.ready;

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (push && !pop)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (out_cnt_reg == 2'd2)
            begin
                out_head_reg <= out_skid_reg;
            end
            else if (push)
            begin
                out_head_reg <= res;
            end
        end
        else if (push)
        begin
            if (out_cnt_reg == 2'd0)
            begin
                out_head_reg <= res;
            end
            else
            begin
                out_skid_reg <= res;
            end
        end
    end

    assign circle.valid     = (out_cnt_reg != 2'd0);
    assign circle.center_re = out_head_reg.center_re;
    assign circle.center_im = out_head_reg.center_im;
    assign circle.radius    = out_head_reg.radius;
    assign circle.status    = out_head_reg.status;

endmodule

### hw/rtl/tpsc_checker.sv
// Port-level assertions for the stability circle block, bound to the top level.
module tpsc_port_props #(
    parameter int RW = tpsc_pkg::RESULT_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [RW-1:0]                 center_re,
    input logic [RW-1:0]                 center_im,
    input logic [RW-1:0]                 radius,
    input logic [tpsc_pkg::STATUS_W-1:0] status
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({center_re, center_im, radius, status}))
        else $error("result changed while stalled");

    // A zero denominator clears all three results
    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == tpsc_pkg::STATUS_ZERO_DEN
        |-> center_re == '0 && center_im == '0 && radius == '0)
        else $error("zero denominator with nonzero result");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == tpsc_pkg::STATUS_OK || status == tpsc_pkg::STATUS_SAT
                      || status == tpsc_pkg::STATUS_ZERO_DEN)
        else $error("undefined status code");

    // Input side only backs up when results are waiting
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("ready low with no result waiting");

endmodule

bind two_port_stability_circle_top tpsc_port_props #(.RW(RESULT_WIDTH)) u_tpsc_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sparam.ready),
    .out_valid (circle.valid),
    .out_ready (circle.ready),
    .center_re (circle.center_re),
    .center_im (circle.center_im),
    .radius    (circle.radius),
    .status    (circle.status)
);

### test/tpsc_checker.sv
// Checker for the stability circle block: predicts each circle and compares transfers.
`timescale 1ns / 1ps

module tpsc_checker (
    input  logic       clk,
    input  logic       rst_n,
    tpsc_in_if         sparam,
    tpsc_out_if        circle,
    output int         fail_count,
    output int         pending
);

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic signed [31:0]                center_re;
        logic signed [31:0]                center_im;
        logic [31:0]                       radius;
        logic [tpsc_pkg::STATUS_W-1:0]     status;
    } circle_t;

    circle_t circle_q[$];

    function automatic logic [63:0] isqrt(logic [159:0] v);
        logic [63:0]  y;
        logic [63:0]  t;
        logic [159:0] tt;
        y = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = y | (64'd1 << i);
            tt = t;
            if (tt * tt <= v)
                y = t;
        end
        return y;
    endfunction

    function automatic logic signed [31:0] clamp_signed(wide_t v, inout logic sat);
        if (v > wide_t'(32'sh7fffffff))
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -wide_t'(64'sh80000000))
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic circle_t predict_circle(
        logic side,
        logic signed [17:0] s11r, logic signed [17:0] s11i,
        logic signed [17:0] s12r, logic signed [17:0] s12i,
        logic signed [17:0] s21r, logic signed [17:0] s21i,
        logic signed [17:0] s22r, logic signed [17:0] s22i);
        wide_t        pr, pi, qr, qi, a12r, a12i, a21r, a21i;
        wide_t        sr, si, dr, di, den, nr, ni;
        logic [159:0] abs_den, rad;
        logic [63:0]  m;
        logic         sat;
        circle_t      c;
        a12r = s12r; a12i = s12i; a21r = s21r; a21i = s21i;
        pr = side ? wide_t'(s22r) : wide_t'(s11r);
        pi = side ? wide_t'(s22i) : wide_t'(s11i);
        qr = side ? wide_t'(s11r) : wide_t'(s22r);
        qi = side ? wide_t'(s11i) : wide_t'(s22i);
        sat = 1'b0;

        sr = a12r * a21r - a12i * a21i;
        si = a12r * a21i + a12i * a21r;
        dr = pr * qr - pi * qi - sr;
        di = pr * qi + pi * qr - si;
        den = ((pr * pr + pi * pi) <<< (2 * tpsc_pkg::IN_FRAC)) - (dr * dr + di * di);
        if (den == 0)
        begin
            c.center_re = '0;
            c.center_im = '0;
            c.radius    = '0;
            c.status    = tpsc_pkg::STATUS_ZERO_DEN;
            return c;
        end

        nr = (pr <<< (2 * tpsc_pkg::IN_FRAC)) - (dr * qr + di * qi);
        ni = (pi <<< (2 * tpsc_pkg::IN_FRAC)) - (di * qr - dr * qi);
        // signed division truncates toward zero
        c.center_re = clamp_signed((nr <<< (tpsc_pkg::OUT_FRAC + tpsc_pkg::IN_FRAC)) / den,
                                   sat);
        c.center_im = clamp_signed((-(ni <<< (tpsc_pkg::OUT_FRAC + tpsc_pkg::IN_FRAC))) / den,
                                   sat);

        m = isqrt(160'(sr * sr + si * si) << (2 * tpsc_pkg::OUT_FRAC));
        abs_den = (den < 0) ? 160'(-den) : 160'(den);
        rad = (160'(m) << (2 * tpsc_pkg::IN_FRAC)) / abs_den;
        if (rad > 160'h0ffff_ffff)
        begin
            sat = 1'b1;
            rad = 160'h0ffff_ffff;
        end
        c.radius = rad[31:0];
        c.status = sat ? tpsc_pkg::STATUS_SAT : tpsc_pkg::STATUS_OK;
        return c;
    endfunction

    always @(posedge clk)
    begin
        circle_t exp_c;
        if (rst_n)
        begin
            if (sparam.valid && sparam.ready)
                circle_q.insert(circle_q.size(), predict_circle(sparam.side,
                    sparam.s11_re, sparam.s11_im, sparam.s12_re, sparam.s12_im,
                    sparam.s21_re, sparam.s21_im, sparam.s22_re, sparam.s22_im));
            if (circle.valid && circle.ready)
            begin
                if (circle_q.size() == 0)
                begin
                    $error("circle transfer with no parameter set waiting");
                    fail_count++;
                end
                else
                begin
                    exp_c = circle_q.pop_front();
                    if (circle.center_re !== exp_c.center_re)
                    begin
                        $error("center_re: expected %0d, got %0d",
                               exp_c.center_re, circle.center_re);
                        fail_count++;
                    end
                    if (circle.center_im !== exp_c.center_im)
                    begin
                        $error("center_im: expected %0d, got %0d",
                               exp_c.center_im, circle.center_im);
                        fail_count++;
                    end
                    if (circle.radius !== exp_c.radius)
                    begin
                        $error("radius: expected %0d, got %0d", exp_c.radius, circle.radius);
                        fail_count++;
                    end
                    if (circle.status !== exp_c.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_c.status, circle.status);
                        fail_count++;
                    end
                end
            end
            pending = circle_q.size();
        end
    end
endmodule

### test/tb_top.sv
// Top of the stability circle testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    localparam int RANDOM_SETS = 1100;
    localparam int CALM_SETS   = 100;
    localparam int IDLE_LIMIT  = 5000;
    localparam logic signed [17:0] SP_MAX = 18'sd131071;
    localparam logic signed [17:0] SP_MIN = -18'sd131072;
    localparam logic signed [17:0] ONE    = 18'sd4096;

    logic clk;
    logic rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    tpsc_in_if  sparam();
    tpsc_out_if circle();

    two_port_stability_circle_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sparam (sparam),
        .circle (circle)
    );

    tpsc_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sparam     (sparam),
        .circle     (circle),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [17:0] rnd_full();
        return 18'($urandom);
    endfunction

    function automatic logic signed [17:0] rnd_small();
        return 18'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic logic signed [17:0] rnd_tiny();
        return 18'($signed($urandom_range(0, 6)) - 3);
    endfunction

    task automatic send_set(input logic side,
                            input logic signed [17:0] a, input logic signed [17:0] b,
                            input logic signed [17:0] c, input logic signed [17:0] d,
                            input logic signed [17:0] e, input logic signed [17:0] f,
                            input logic signed [17:0] g, input logic signed [17:0] h);
        sparam.valid  <= 1'b1;
        sparam.side   <= side;
        sparam.s11_re <= a;
        sparam.s11_im <= b;
        sparam.s12_re <= c;
        sparam.s12_im <= d;
        sparam.s21_re <= e;
        sparam.s21_im <= f;
        sparam.s22_re <= g;
        sparam.s22_im <= h;
        do
            @(posedge clk);
        while (!sparam.ready);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            sparam.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    // receiver: one long hold-off to fill the pipeline, then random stall bursts
    initial
    begin
        circle.ready = 1'b0;
        @(posedge rst_n);
        repeat (300) @(negedge clk);
        circle.ready <= 1'b0;
        repeat (400) @(negedge clk);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                circle.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                circle.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((sparam.valid && sparam.ready) || (circle.valid && circle.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic signed [17:0] q_re;
        logic signed [17:0] q_im;
        int mode;
        calm = 1'b0;
        rst_n = 1'b0;
        sparam.valid = 1'b0;
        sparam.side = 1'b0;
        sparam.s11_re = '0; sparam.s11_im = '0;
        sparam.s12_re = '0; sparam.s12_im = '0;
        sparam.s21_re = '0; sparam.s21_im = '0;
        sparam.s22_re = '0; sparam.s22_im = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero denominators: all zero, and unit-magnitude reflection on the far port
        send_set(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_set(1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_set(0, ONE, 0, 0, 0, 0, 0, ONE, 0);
        send_set(1, 0, ONE, 0, 0, 0, 0, 0, -ONE);
        // field extremes
        send_set(0, SP_MAX, SP_MAX, SP_MAX, SP_MAX, SP_MAX, SP_MAX, SP_MAX, SP_MAX);
        send_set(1, SP_MIN, SP_MIN, SP_MIN, SP_MIN, SP_MIN, SP_MIN, SP_MIN, SP_MIN);
        send_set(0, SP_MIN, SP_MAX, SP_MIN, SP_MAX, SP_MAX, SP_MIN, SP_MAX, SP_MIN);
        send_set(1, SP_MAX, SP_MIN, SP_MAX, SP_MIN, SP_MIN, SP_MAX, SP_MIN, SP_MAX);
        // tiny delta against a large far-port reflection: saturation
        send_set(0, 0, 0, 1, 0, 1, 0, SP_MAX, 0);
        send_set(1, 0, 0, 1, 0, 1, 0, SP_MAX, 0);
        send_set(0, 0, 0, 1, 0, -1, 0, SP_MIN, 0);
        send_set(1, SP_MIN, SP_MAX, 0, 1, 1, 0, 0, 0);
        // typical amplifier-like sets on both sides
        send_set(0, 18'sd2048, -18'sd900, 18'sd400, 18'sd120, 18'sd8000, 18'sd3000,
                 18'sd1500, -18'sd2200);
        send_set(1, 18'sd2048, -18'sd900, 18'sd400, 18'sd120, 18'sd8000, 18'sd3000,
                 18'sd1500, -18'sd2200);
        send_set(0, ONE, 0, ONE, 0, 18'sd8191, 0, ONE, 0);
        send_set(1, 18'sd1, 18'sd0, 0, 0, 0, 0, 18'sd4095, 0);

        for (int n = 0; n < RANDOM_SETS; n++)
        begin
            if (n == RANDOM_SETS - CALM_SETS)
                calm = 1'b1;
            mode = $urandom_range(0, 9);
            if (mode < 4)
                send_set(1'($urandom), rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                         rnd_full(), rnd_full(), rnd_full(), rnd_full());
            else if (mode < 7)
                send_set(1'($urandom), rnd_small(), rnd_small(), rnd_small(), rnd_small(),
                         rnd_small(), rnd_small(), rnd_small(), rnd_small());
            else if (mode < 9)
                // near-singular: one port reflection near zero, small delta
                send_set(1'($urandom), 0, rnd_tiny(), rnd_tiny(), rnd_tiny(),
                         rnd_tiny(), rnd_tiny(), rnd_full(), rnd_full());
            else
            begin
                // far port on the unit circle, no feedback: zero denominator
                q_re = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
                q_im = 0;
                if ($urandom_range(0, 1) != 0)
                begin
                    q_im = q_re;
                    q_re = 0;
                end
                send_set(0, rnd_full(), rnd_full(), 0, 0, 0, 0, q_re, q_im);
            end
        end
        sparam.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
